// ===== rtl/lse_pkg.sv =====
// Shared types, codes and saturating arithmetic for the Legendre series evaluator.
package lse_pkg;

  typedef logic signed [63:0] acc_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam int CNT_W   = 5;
  localparam int IDX_W   = 4;
  localparam int COEF_W  = 32;
  localparam int X_W     = 16;
  localparam int OUT_W   = 40;
  localparam int IN_DW   = 56;

  localparam acc_t ACC_MAX = {1'b0, {63{1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {63{1'b0}}};

  function automatic acc_t add_sat(acc_t a, acc_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) begin
      return s[64] ? ACC_MIN : ACC_MAX;
    end
    return s[63:0];
  endfunction

endpackage

// ===== rtl/legendre_series_evaluator.sv =====
// Legendre series evaluator: one evaluate transaction enters per clock
// while no result waits at the output; it passes the head stages, then the
// chain of six-stage recurrence units, one per degree from 2 up, each with
// its own reciprocal multiplier for the divide by n, then the output register.
// Loads write the coefficient table and give no result; a load waits until
// no evaluate is in flight in the chain, so it never alters a sum under way.
// The whole pipeline holds while a result waits at the output.
module legendre_series_evaluator import lse_pkg::*; #(
  parameter int MAX_COEFFS  = 16,
  parameter int X_FRAC_BITS = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // coefficient_index[3:0], coefficient_value[35:4], x_value[51:36], zero pad
  input  logic [IN_DW-1:0] in_tdata,
  // op[0]
  input  logic [0:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // series_value[39:0]
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam int F  = X_FRAC_BITS;
  localparam int PW = F + 2;
  localparam int NL = MAX_COEFFS - 1;

  logic [CNT_W-1:0]         cnt_r;
  logic signed [COEF_W-1:0] coef_r [MAX_COEFFS];
  logic                     en;
  logic                     busy;
  logic                     in_acc;
  logic                     eval_acc;
  logic [IDX_W-1:0]         idx;
  logic signed [COEF_W-1:0] cval;
  logic signed [X_W-1:0]    xval;

  logic                     lk_vld [NL];
  logic signed [X_W-1:0]    lk_x   [NL];
  logic signed [PW-1:0]     lk_p1  [NL];
  logic signed [PW-1:0]     lk_p2  [NL];
  acc_t                     lk_acc [NL];
  logic [NL-1:0]            busy_v;

  assign idx  = in_tdata[IDX_W-1:0];
  assign cval = in_tdata[IDX_W +: COEF_W];
  assign xval = in_tdata[IDX_W + COEF_W +: X_W];

  assign en        = !out_tvalid || out_tready;
  assign busy      = |busy_v;
  assign in_tready = en && ((in_tuser[0] == OP_EVAL) || !busy);
  assign in_acc    = in_tvalid && in_tready;
  assign eval_acc  = in_acc && (in_tuser[0] == OP_EVAL);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      cnt_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_COEFFS; i++) begin
      if (in_acc && (in_tuser[0] == OP_LOAD) && (int'(idx) == i)) begin
        coef_r[i] <= cval;
      end
    end
  end

  lse_head #(.F(F)) u_head (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (eval_acc),
    .x_i    (xval),
    .c0_i   (coef_r[0]),
    .c1_i   (coef_r[1]),
    .cnt_i  (cnt_r),
    .vld_o  (lk_vld[0]),
    .x_o    (lk_x[0]),
    .p1_o   (lk_p1[0]),
    .p2_o   (lk_p2[0]),
    .acc_o  (lk_acc[0]),
    .busy_o (busy_v[0])
  );

  for (genvar n = 2; n < MAX_COEFFS; n++) begin : g_step
    lse_step #(.N(n), .F(F)) u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (lk_vld[n-2]),
      .x_i    (lk_x[n-2]),
      .p1_i   (lk_p1[n-2]),
      .p2_i   (lk_p2[n-2]),
      .acc_i  (lk_acc[n-2]),
      .c_i    (coef_r[n]),
      .cnt_i  (cnt_r),
      .vld_o  (lk_vld[n-1]),
      .x_o    (lk_x[n-1]),
      .p1_o   (lk_p1[n-1]),
      .p2_o   (lk_p2[n-1]),
      .acc_o  (lk_acc[n-1]),
      .busy_o (busy_v[n-1])
    );
  end

  lse_tail #(.F(F)) u_tail (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vld_i     (lk_vld[NL-1]),
    .acc_i     (lk_acc[NL-1]),
    .out_valid (out_tvalid),
    .out_data  (out_tdata)
  );

`ifndef SYNTH
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser[0] == OP_LOAD)) |-> !busy)
    else $error("load taken with evaluate in flight");

  a_ready_en: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> en)
    else $error("input ready while pipeline stalled");

  a_empty_out: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !out_tvalid && !eval_acc) |=> !out_tvalid)
    else $error("result appeared from empty pipeline");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(busy_v))
    else $error("pipeline moved during stall");
`endif

endmodule

// ===== rtl/lse_head.sv =====
// Head stages: clamps x, forms the P0 and P1 terms of the series.
module lse_head import lse_pkg::*; #(
  parameter int F = 14,
  localparam int PW = F + 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     vld_i,
  input  logic signed [X_W-1:0]    x_i,
  input  logic signed [COEF_W-1:0] c0_i,
  input  logic signed [COEF_W-1:0] c1_i,
  input  logic [CNT_W-1:0]         cnt_i,
  output logic                     vld_o,
  output logic signed [X_W-1:0]    x_o,
  output logic signed [PW-1:0]     p1_o,
  output logic signed [PW-1:0]     p2_o,
  output acc_t                     acc_o,
  output logic                     busy_o
);

  localparam int XW = ((PW > X_W) ? PW : X_W) + 1;
  localparam int TW = COEF_W + PW;
  localparam logic signed [XW-1:0] PHI = XW'((64'sd1 <<< (F + 1)) - 64'sd1);
  localparam logic signed [XW-1:0] PLO = XW'(-(64'sd1 <<< (F + 1)));

  logic [1:0]               vld_r;
  logic signed [XW-1:0]     xe;
  logic signed [XW-1:0]     pc;
  logic signed [PW-1:0]     p1c;
  logic signed [TW-1:0]     t1_r;
  acc_t                     c0t_r;
  logic signed [X_W-1:0]    x0_r, x1_r;
  logic signed [PW-1:0]     p0_r, p1_r;
  acc_t                     acc_r;

  always_comb begin
    xe  = XW'(x_i);
    pc  = (xe > PHI) ? PHI : ((xe < PLO) ? PLO : xe);
    p1c = PW'(pc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r  <= (cnt_i >= CNT_W'(2)) ? TW'(c1_i) * TW'(p1c) : '0;
      c0t_r <= acc_t'(c0_i) <<< F;
      x0_r  <= x_i;
      p0_r  <= p1c;
      acc_r <= add_sat(c0t_r, acc_t'(t1_r));
      x1_r  <= x0_r;
      p1_r  <= p0_r;
    end
  end

  assign vld_o  = vld_r[1];
  assign x_o    = x1_r;
  assign p1_o   = p1_r;
  assign p2_o   = PW'(1) <<< F;
  assign acc_o  = acc_r;
  assign busy_o = |vld_r;

endmodule

// ===== rtl/lse_step.sv =====
// One Bonnet recurrence step for degree N, six register stages deep.
module lse_step import lse_pkg::*; #(
  parameter int N = 2,
  parameter int F = 14,
  localparam int PW = F + 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     vld_i,
  input  logic signed [X_W-1:0]    x_i,
  input  logic signed [PW-1:0]     p1_i,
  input  logic signed [PW-1:0]     p2_i,
  input  acc_t                     acc_i,
  input  logic signed [COEF_W-1:0] c_i,
  input  logic [CNT_W-1:0]         cnt_i,
  output logic                     vld_o,
  output logic signed [X_W-1:0]    x_o,
  output logic signed [PW-1:0]     p1_o,
  output logic signed [PW-1:0]     p2_o,
  output acc_t                     acc_o,
  output logic                     busy_o
);

  localparam int XPW = X_W + PW;
  localparam int NW  = (((F + 23) > (2 * F + 7)) ? (F + 23) : (2 * F + 7)) + 2;
  localparam int QW  = F + 8;
  localparam int S   = QW + 7;
  localparam int PRW = QW + S + 1;
  localparam int TW  = COEF_W + PW;
  localparam longint unsigned RV = ((64'd1 << S) + 64'(N) - 64'd1) / 64'(N);
  localparam logic [S:0] R = (S + 1)'(RV);
  localparam logic [NW-1:0] CAP = NW'(64'(N) << (F + 1));
  localparam logic signed [NW-1:0] K1 = NW'(2 * N - 1);
  localparam logic signed [NW-1:0] K2 = NW'(N - 1);
  localparam logic [F+1:0] PHI = (F + 2)'((64'd1 << (F + 1)) - 64'd1);

  logic [5:0]              vld_r;
  logic signed [XPW-1:0]   s0_xp_r;
  logic signed [PW-1:0]    s0_p1_r, s0_p2_r, s1_p1_r, s2_p1_r, s3_p1_r, s4_p1_r, s5_p1_r;
  logic signed [PW-1:0]    s3_p_r, s4_p_r, s5_p_r;
  logic signed [X_W-1:0]   s0_x_r, s1_x_r, s2_x_r, s3_x_r, s4_x_r, s5_x_r;
  acc_t                    s0_acc_r, s1_acc_r, s2_acc_r, s3_acc_r, s4_acc_r, s5_acc_r;
  logic                    s0_use_r, s1_use_r, s2_use_r, s3_use_r, s4_use_r;
  logic                    s1_neg_r, s2_neg_r;
  logic [QW-1:0]           s1_q0_r;
  logic [PRW-1:0]          s2_prod_r;
  logic signed [TW-1:0]    s4_term_r;

  logic signed [NW-1:0]    num;
  logic [NW-1:0]           mag;
  logic [NW-1:0]           sh;
  logic [QW-1:0]           q0_nxt;
  logic [F+1:0]            q;
  logic signed [PW-1:0]    p_nxt;

  always_comb begin
    num    = NW'(s0_xp_r) * K1 - ((NW'(s0_p2_r) * K2) <<< F);
    mag    = num[NW-1] ? NW'(-num) : NW'(num);
    sh     = mag >> F;
    q0_nxt = (sh > CAP) ? QW'(CAP) : QW'(sh);
    q      = s2_prod_r[S +: F + 2];
    if (s2_neg_r) begin
      p_nxt = -PW'(q);
    end else begin
      p_nxt = (q > PHI) ? PW'(PHI) : PW'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_xp_r   <= XPW'(x_i) * XPW'(p1_i);
      s0_p1_r   <= p1_i;
      s0_p2_r   <= p2_i;
      s0_x_r    <= x_i;
      s0_acc_r  <= acc_i;
      s0_use_r  <= (N < int'(cnt_i));

      s1_neg_r  <= num[NW-1];
      s1_q0_r   <= q0_nxt;
      s1_p1_r   <= s0_p1_r;
      s1_x_r    <= s0_x_r;
      s1_acc_r  <= s0_acc_r;
      s1_use_r  <= s0_use_r;

      s2_prod_r <= PRW'(s1_q0_r) * PRW'(R);
      s2_neg_r  <= s1_neg_r;
      s2_p1_r   <= s1_p1_r;
      s2_x_r    <= s1_x_r;
      s2_acc_r  <= s1_acc_r;
      s2_use_r  <= s1_use_r;

      s3_p_r    <= p_nxt;
      s3_p1_r   <= s2_p1_r;
      s3_x_r    <= s2_x_r;
      s3_acc_r  <= s2_acc_r;
      s3_use_r  <= s2_use_r;

      s4_term_r <= TW'(c_i) * TW'(s3_p_r);
      s4_p_r    <= s3_p_r;
      s4_p1_r   <= s3_p1_r;
      s4_x_r    <= s3_x_r;
      s4_acc_r  <= s3_acc_r;
      s4_use_r  <= s3_use_r;

      s5_acc_r  <= s4_use_r ? add_sat(s4_acc_r, acc_t'(s4_term_r)) : s4_acc_r;
      s5_p_r    <= s4_p_r;
      s5_p1_r   <= s4_p1_r;
      s5_x_r    <= s4_x_r;
    end
  end

  assign vld_o  = vld_r[5];
  assign x_o    = s5_x_r;
  assign p1_o   = s5_p_r;
  assign p2_o   = s5_p1_r;
  assign acc_o  = s5_acc_r;
  assign busy_o = |vld_r;

endmodule

// ===== rtl/lse_tail.sv =====
// Output register: floor shift of the accumulator and 40-bit saturation.
module lse_tail import lse_pkg::*; #(
  parameter int F = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_i,
  input  acc_t             acc_i,
  output logic             out_valid,
  output logic [OUT_W-1:0] out_data
);

  localparam acc_t OMAX = acc_t'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam acc_t OMIN = acc_t'(-(64'sd1 <<< (OUT_W - 1)));

  acc_t             sh;
  acc_t             cl;
  logic             vld_r;
  logic [OUT_W-1:0] data_r;

  always_comb begin
    sh = acc_i >>> F;
    cl = (sh > OMAX) ? OMAX : ((sh < OMIN) ? OMIN : sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= cl[OUT_W-1:0];
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule
